// ===== rtl/scfe_pkg.sv =====
// Shared types, constants and the CRC byte step for the servo command frame encoder.
// No dependencies; every other file imports this package.
`default_nettype none

package scfe_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_POSITION = 2'd0,
      REQ_EE_WRITE = 2'd1,
      REQ_EE_UNLOCK = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   localparam int PAYLOAD_LEN = 4;
   localparam int FRAME_LEN = 6;
   localparam int QUEUE_DEPTH = 2;

   // Byte slots within a frame
   localparam logic [2:0] SLOT_FIRST = 3'd0;
   localparam logic [2:0] SLOT_CRC_HI = 3'd4;
   localparam logic [2:0] SLOT_CRC_LO = 3'd5;

   // CRC-16, MSB first
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Position scaling
   localparam logic [11:0] CMD_CENTER = 12'h800;
   localparam logic [11:0] CMD_SPAN = 12'h360;
   localparam logic [13:0] POS_FULL = 14'd8191;

   // Frame header bytes
   localparam logic [7:0] HDR_POSITION = 8'hDD;
   localparam logic [7:0] HDR_POS_SUB = 8'h01;
   localparam logic [7:0] HDR_EE_WRITE = 8'hE8;
   localparam logic [7:0] HDR_EE_SUB = 8'h1F;
   localparam logic [7:0] HDR_UNLOCK = 8'hFF;
   localparam logic [7:0] UNLOCK_KEY_A = 8'h41;
   localparam logic [7:0] UNLOCK_KEY_B = 8'h3F;

   // Payload byte 0 goes out first
   typedef logic [PAYLOAD_LEN-1:0][7:0] payload_type;

   // Write side of the frame queue
   typedef struct packed {
      logic push;
      payload_type payload;
   } queue_wr_type;

   // Fold one byte into the running CRC
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/servo_command_frame_encoder_top.sv =====
// Top level of the servo command frame encoder: front end, frame queue, serializer.
// Depends on scfe_pkg, scfe_front, scfe_queue and scfe_back.
`default_nettype none

// Each request that produces a frame yields six bytes on the rsp channel, one
// per cycle while rsp_stall is low, with rsp_last_byte on the sixth: four payload
// bytes and the CRC-16 (0x8005, init 0xFFFF) high byte first. The serializer
// sends one byte a cycle unless rsp_stall holds it. The front end takes a
// request whenever the frame queue (QUEUE_DEPTH entries) has room; position
// requests that repeat the last sent value or lie outside -8190..8190, and
// request kind 3, are taken and produce nothing.
module servo_command_frame_encoder_top #(
   parameter int QUEUE_DEPTH = scfe_pkg::QUEUE_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_type,
   input wire logic signed [13:0] req_position,
   input wire logic [7:0] req_eeprom_addr,
   input wire logic [7:0] req_eeprom_value,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_last_byte
);
   import scfe_pkg::*;

   queue_wr_type queue_wr;
   payload_type head;
   logic queue_full;
   logic queue_empty;
   logic pop;

   scfe_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_position(req_position),
      .req_eeprom_addr(req_eeprom_addr),
      .req_eeprom_value(req_eeprom_value),
      .queue_full(queue_full),
      .queue_wr(queue_wr)
   );

   scfe_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .queue_wr(queue_wr),
      .pop(pop),
      .full(queue_full),
      .empty(queue_empty),
      .head(head)
   );

   scfe_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(!queue_empty),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte)
   );

endmodule

`default_nettype wire

// ===== rtl/scfe_front.sv =====
// Front end: accepts requests, filters repeated or out-of-range positions and
// builds the four payload bytes. Depends on scfe_pkg.
`default_nettype none

module scfe_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_type,
   input wire logic signed [13:0] req_position,
   input wire logic [7:0] req_eeprom_addr,
   input wire logic [7:0] req_eeprom_value,
   input wire logic queue_full,
   output scfe_pkg::queue_wr_type queue_wr
);
   import scfe_pkg::*;

   localparam logic signed [13:0] POS_MIN_A = -14'sd8192;
   localparam logic signed [13:0] POS_MIN_B = -14'sd8191;
   localparam logic signed [13:0] POS_MAX = 14'sd8191;

   logic [13:0] last_pos_ff, last_pos_in;
   logic last_valid_ff, last_valid_in;

   logic accept;
   logic out_of_range;
   logic repeated;
   logic [14:0] shifted_wide;
   logic [13:0] shifted;
   logic [23:0] product;
   logic [10:0] quot_est;
   logic [13:0] rem_est;
   logic [10:0] quot;
   logic [11:0] cmd;
   logic keep;
   payload_type payload;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;

   // Classify position requests
   assign out_of_range = (req_position == POS_MIN_A) || (req_position == POS_MIN_B) ||
                         (req_position == POS_MAX);
   assign repeated = last_valid_ff && (req_position == last_pos_ff);

   // Scale: floor((pos + 8191) * 864 / 8191); divide by 2^13-1 with one correction
   assign shifted_wide = {req_position[13], req_position} + {1'b0, POS_FULL};
   assign shifted = shifted_wide[13:0];
   assign product = 24'(shifted) * 24'(CMD_SPAN);
   assign quot_est = product[23:13];
   assign rem_est = {1'b0, product[12:0]} + 14'(quot_est);
   assign quot = quot_est + 11'(rem_est >= POS_FULL);
   assign cmd = (CMD_CENTER - CMD_SPAN) + 12'(quot);

   // Build payload and decide whether the item produces a frame
   always_comb begin
      keep = 1'b0;
      payload = '0;
      unique case (req_kind_type'(req_type))
         REQ_POSITION: begin
            keep = !out_of_range && !repeated;
            payload[0] = HDR_POSITION;
            payload[1] = HDR_POS_SUB;
            payload[2] = {3'b000, cmd[11:7]};
            payload[3] = {1'b0, cmd[6:0]};
         end
         REQ_EE_WRITE: begin
            keep = 1'b1;
            payload[0] = HDR_EE_WRITE;
            payload[1] = HDR_EE_SUB;
            payload[2] = req_eeprom_addr;
            payload[3] = req_eeprom_value;
         end
         REQ_EE_UNLOCK: begin
            keep = 1'b1;
            payload[0] = HDR_UNLOCK;
            payload[1] = HDR_EE_SUB;
            payload[2] = UNLOCK_KEY_A;
            payload[3] = UNLOCK_KEY_B;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign queue_wr.push = accept && keep;
   assign queue_wr.payload = payload;

   // Remember the last position sent
   always_comb begin
      last_pos_in = last_pos_ff;
      last_valid_in = last_valid_ff;
      if (queue_wr.push && (req_kind_type'(req_type) == REQ_POSITION)) begin
         last_pos_in = req_position;
         last_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= '0;
         last_valid_ff <= 1'b0;
      end else begin
         last_pos_ff <= last_pos_in;
         last_valid_ff <= last_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scfe_queue.sv =====
// Small frame queue between front end and serializer, one payload per entry.
// Depends on scfe_pkg.
`default_nettype none

module scfe_queue #(
   parameter int DEPTH = scfe_pkg::QUEUE_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input scfe_pkg::queue_wr_type queue_wr,
   input wire logic pop,
   output logic full,
   output logic empty,
   output scfe_pkg::payload_type head
);
   import scfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   payload_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (queue_wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (queue_wr.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !queue_wr.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Hold entry storage
   always_ff @(posedge clock) begin
      if (queue_wr.push) begin
         entry_ff[wr_ptr_ff] <= queue_wr.payload;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scfe_back.sv =====
// Serializer: sends the queue head byte by byte, folds the CRC in as the
// payload goes out and appends it. Depends on scfe_pkg.
`default_nettype none

module scfe_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic head_valid,
   input scfe_pkg::payload_type head,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_last_byte
);
   import scfe_pkg::*;

   logic [2:0] slot_ff, slot_in;
   logic [15:0] crc_ff, crc_in;
   logic valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in;

   logic load;
   logic [7:0] byte_sel;
   logic [15:0] crc_src;

   // Load a new byte when the output register is free or being taken
   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop = load && (slot_ff == SLOT_CRC_LO);

   // Pick the byte for the current slot
   always_comb begin
      case (slot_ff)
         SLOT_CRC_HI: byte_sel = crc_ff[15:8];
         SLOT_CRC_LO: byte_sel = crc_ff[7:0];
         default: byte_sel = head[slot_ff[1:0]];
      endcase
   end

   assign crc_src = (slot_ff == SLOT_FIRST) ? CRC_INIT : crc_ff;

   always_comb begin
      slot_in = slot_ff;
      crc_in = crc_ff;
      valid_in = valid_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in = byte_sel;
         last_in = (slot_ff == SLOT_CRC_LO);
         slot_in = (slot_ff == SLOT_CRC_LO) ? SLOT_FIRST : slot_ff + 1'b1;
         if (slot_ff < SLOT_CRC_HI) begin
            crc_in = crc_byte(crc_src, byte_sel);
         end
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_FIRST;
         valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

`default_nettype wire

// ===== tb/sv/scfe_frame_checker.sv =====
// Frame checker for the servo command frame encoder: predicts six-byte frames and compares.
// Depends on scfe_pkg for request kinds, header bytes and CRC constants.
module scfe_frame_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic [1:0] req_type,
   input wire logic signed [13:0] req_position,
   input wire logic [7:0] req_eeprom_addr,
   input wire logic [7:0] req_eeprom_value,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic rsp_last_byte,
   output int error_count,
   output int bytes_pending,
   output int frames_built,
   output int requests_seen,
   output int bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import scfe_pkg::*;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic last_byte;
   } frame_slot_type;

   frame_slot_type bytes_due[$];
   logic signed [13:0] sent_position;
   logic sent_position_ok;
   int errs = 0;
   int built = 0;
   int seen = 0;
   int checked = 0;

   // Map a position in -8190..8190 onto the 12-bit command word
   function automatic logic [11:0] scale_position(input logic signed [13:0] pos);
      int shifted;
      int q;
      shifted = int'(pos) + 8191;
      q = (shifted * 864) / 8191;
      return 12'(2048 - 864 + q);
   endfunction

   // CRC-16 over the payload, one bit at a time, MSB first
   function automatic logic [15:0] payload_crc(input logic [31:0] payload);
      logic [15:0] crc;
      logic feedback;
      crc = CRC_INIT;
      for (int i = 31; i >= 0; i--) begin
         feedback = crc[15] ^ payload[i];
         crc = {crc[14:0], 1'b0};
         if (feedback) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   always @(posedge clock) begin
      frame_slot_type due;
      logic [31:0] payload;
      logic [15:0] crc;
      logic [11:0] cmd;
      logic emit;
      if (reset) begin
         bytes_due.delete();
         sent_position = '0;
         sent_position_ok = 1'b0;
      end else begin
         // Compare an accepted frame byte with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (bytes_due.size() == 0) begin
               errs++;
               $error("unexpected frame byte %02h last %0b", rsp_frame_byte, rsp_last_byte);
            end else begin
               due = bytes_due.pop_front();
               if (rsp_frame_byte !== due.frame_byte) begin
                  errs++;
                  $error("frame_byte: expected %02h, got %02h", due.frame_byte,
                         rsp_frame_byte);
               end
               if (rsp_last_byte !== due.last_byte) begin
                  errs++;
                  $error("last_byte: expected %0b, got %0b", due.last_byte, rsp_last_byte);
               end
            end
         end
         // Build the frame for an accepted request, or drop it
         if (req_valid && !req_stall) begin
            seen++;
            emit = 1'b1;
            payload = '0;
            case (req_kind_type'(req_type))
               REQ_POSITION: begin
                  if (req_position < -8190 || req_position > 8190) begin
                     emit = 1'b0;
                  end else if (sent_position_ok && req_position == sent_position) begin
                     emit = 1'b0;
                  end else begin
                     cmd = scale_position(req_position);
                     payload = {HDR_POSITION, HDR_POS_SUB, 3'b000, cmd[11:7], 1'b0, cmd[6:0]};
                     sent_position = req_position;
                     sent_position_ok = 1'b1;
                  end
               end
               REQ_EE_WRITE: begin
                  payload = {HDR_EE_WRITE, HDR_EE_SUB, req_eeprom_addr, req_eeprom_value};
               end
               REQ_EE_UNLOCK: begin
                  payload = {HDR_UNLOCK, HDR_EE_SUB, UNLOCK_KEY_A, UNLOCK_KEY_B};
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            if (emit) begin
               built++;
               crc = payload_crc(payload);
               for (int k = 0; k < PAYLOAD_LEN; k++) begin
                  bytes_due.push_back('{payload[31 - 8 * k -: 8], 1'b0});
               end
               bytes_due.push_back('{crc[15:8], 1'b0});
               bytes_due.push_back('{crc[7:0], 1'b1});
            end
         end
      end
      error_count <= errs;
      bytes_pending <= bytes_due.size();
      frames_built <= built;
      requests_seen <= seen;
      bytes_checked <= checked;
   end

endmodule

// ===== tb/sv/servo_command_frame_encoder_top_tb.sv =====
// Testbench top for the servo command frame encoder: clock, reset, requests and stalls.
// Depends on scfe_pkg, servo_command_frame_encoder_top and scfe_frame_checker.
module servo_command_frame_encoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scfe_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_REQUESTS = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [1:0] req_type = REQ_POSITION;
   logic signed [13:0] req_position = '0;
   logic [7:0] req_eeprom_addr = '0;
   logic [7:0] req_eeprom_value = '0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic [7:0] rsp_frame_byte;
   logic rsp_last_byte;

   int error_count;
   int bytes_pending;
   int frames_built;
   int requests_seen;
   int bytes_checked;
   int cycle_count = 0;
   int recent_position = 0;
   bit gaps_on = 1'b1;

   always #5 clock = ~clock;

   servo_command_frame_encoder_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_position(req_position),
      .req_eeprom_addr(req_eeprom_addr),
      .req_eeprom_value(req_eeprom_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte)
   );

   scfe_frame_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_position(req_position),
      .req_eeprom_addr(req_eeprom_addr),
      .req_eeprom_value(req_eeprom_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte),
      .error_count(error_count),
      .bytes_pending(bytes_pending),
      .frames_built(frames_built),
      .requests_seen(requests_seen),
      .bytes_checked(bytes_checked)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("servo_command_frame_encoder_top_tb: errors");
         $finish;
      end
   end

   // Present one request, after a random gap when gaps_on is set, and hold it until taken
   task automatic send_request(input logic [1:0] kind, input int pos,
                               input logic [7:0] addr, input logic [7:0] value);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_position <= 14'(pos);
      req_eeprom_addr <= addr;
      req_eeprom_value <= value;
      if (kind == REQ_POSITION) begin
         recent_position = pos;
      end
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off requests until every predicted byte has come out
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stall the result side at random before each byte while gaps_on is set
   initial begin
      int unsigned hold;
      forever begin
         hold = gaps_on ? $urandom_range(0, 15) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int unsigned pick;
      int pos;
      int extremes[8];
      extremes = '{-8192, -8191, -8190, -1, 0, 1, 8190, 8191};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: range edges, repeats, every request kind
      send_request(REQ_POSITION, 0, 8'h00, 8'h00);
      send_request(REQ_POSITION, 0, 8'h00, 8'h00);
      send_request(REQ_POSITION, 8190, 8'h00, 8'h00);
      send_request(REQ_POSITION, -8190, 8'h00, 8'h00);
      send_request(REQ_POSITION, 8191, 8'h00, 8'h00);
      send_request(REQ_POSITION, -8191, 8'h00, 8'h00);
      send_request(REQ_POSITION, -8192, 8'h00, 8'h00);
      send_request(REQ_POSITION, 1, 8'h00, 8'h00);
      send_request(REQ_POSITION, -1, 8'h00, 8'h00);
      send_request(REQ_EE_WRITE, 8191, 8'h00, 8'h00);
      send_request(REQ_EE_WRITE, -8192, 8'hFF, 8'hFF);
      send_request(REQ_EE_WRITE, 0, 8'hA5, 8'h5A);
      send_request(REQ_EE_WRITE, -1, 8'h5A, 8'hA5);
      send_request(REQ_POSITION, -1, 8'h00, 8'h00);
      send_request(REQ_EE_UNLOCK, 0, 8'h00, 8'h00);
      send_request(REQ_EE_UNLOCK, -1, 8'hFF, 8'hFF);
      send_request(REQ_UNUSED, 4095, 8'h3C, 8'hC3);
      send_request(REQ_POSITION, 4095, 8'h00, 8'h00);
      send_request(REQ_POSITION, -4096, 8'h00, 8'h00);
      send_request(REQ_POSITION, 8189, 8'h00, 8'h00);
      send_request(REQ_POSITION, -8189, 8'h00, 8'h00);
      hold_until_drained();

      // Random: mostly frame-producing requests, some repeats and noise
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 25 == 0) begin
            gaps_on = ($urandom_range(0, 2) != 0);
         end
         if (n == 70) begin
            hold_until_drained();
         end
         pick = $urandom_range(0, 99);
         pos = int'($urandom_range(0, 16383)) - 8192;
         if (pick < 40) begin
            send_request(REQ_POSITION, pos, 8'($urandom), 8'($urandom));
         end else if (pick < 50) begin
            send_request(REQ_POSITION, extremes[$urandom_range(0, 7)], 8'($urandom),
                         8'($urandom));
         end else if (pick < 62) begin
            send_request(REQ_POSITION, recent_position, 8'($urandom), 8'($urandom));
         end else if (pick < 80) begin
            send_request(REQ_EE_WRITE, pos, 8'($urandom), 8'($urandom));
         end else if (pick < 94) begin
            send_request(REQ_EE_UNLOCK, pos, 8'($urandom), 8'($urandom));
         end else begin
            send_request(REQ_UNUSED, pos, 8'($urandom), 8'($urandom));
         end
      end
      gaps_on = 1'b1;
      hold_until_drained();

      $display("covered %0d requests of all kinds, %0d frames built, %0d bytes checked",
               requests_seen, frames_built, bytes_checked);
      if (error_count == 0) begin
         $display("servo_command_frame_encoder_top_tb: clean");
      end else begin
         $display("servo_command_frame_encoder_top_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/scfe_pkg.sv
rtl/scfe_front.sv
rtl/scfe_queue.sv
rtl/scfe_back.sv
rtl/servo_command_frame_encoder_top.sv
tb/sv/scfe_frame_checker.sv
tb/sv/servo_command_frame_encoder_top_tb.sv
